// ===== design/vcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// vcfr_pkg
// Shared types and constants of the velocity command frame receiver.
// ----------------------------------------------------------------------------
package vcfr_pkg;

    // parser phases
    localparam logic [2:0] PH_HEAD0 = 3'd0;
    localparam logic [2:0] PH_HEAD1 = 3'd1;
    localparam logic [2:0] PH_TYPE  = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_TAIL  = 3'd4;

    // byte positions inside a frame
    localparam logic [3:0] FIRST_DATA_POS = 4'd3;
    localparam logic [3:0] CHECK_POS      = 4'd11;
    localparam logic [3:0] TAIL_POS       = 4'd12;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_WIDTH = 3;
    localparam logic [2:0] CFG_FIRST_HEADER  = 3'd0;
    localparam logic [2:0] CFG_SECOND_HEADER = 3'd1;
    localparam logic [2:0] CFG_VELOCITY_TYPE = 3'd2;
    localparam logic [2:0] CFG_TAIL_BYTE     = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT_MS    = 3'd4;

    localparam int unsigned CFG_DATA_WIDTH = 16;

    // item kinds
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // result kinds
    localparam logic EVENT_COMMAND = 1'b0;
    localparam logic EVENT_STOP    = 1'b1;

    typedef struct packed {
        logic [7:0] first_header;
        logic [7:0] second_header;
        logic [7:0] velocity_type;
        logic [7:0] tail_byte;
    } frame_match_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] linear_speed_bits;
        logic [31:0] turn_rate_bits;
    } command_t;

endpackage

// ===== design/vcfr_if.sv =====
// ----------------------------------------------------------------------------
// vcfr_if
// Valid/ready channels of the receiver: input items, results, config writes.
// ----------------------------------------------------------------------------
interface vcfr_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] data_byte;

    modport source (output valid, output func, output data_byte, input ready);
    modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface vcfr_result_if;
    logic        valid;
    logic        ready;
    logic        event_kind;
    logic [31:0] linear_speed_bits;
    logic [31:0] turn_rate_bits;

    modport source (output valid, output event_kind, output linear_speed_bits,
                    output turn_rate_bits, input ready);
    modport sink   (input valid, input event_kind, input linear_speed_bits,
                    input turn_rate_bits, output ready);
endinterface

interface vcfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/vcfr_parser.sv =====
// ----------------------------------------------------------------------------
// vcfr_parser
// Frame hunter: headers, type, payload capture, running xor, check and tail.
// ----------------------------------------------------------------------------
module vcfr_parser
    import vcfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_en,
    input  logic [7:0]   data_byte,
    input  frame_match_t match,
    output command_t     command
);

    logic [2:0] phase_reg, phase_next;
    logic [3:0] pos_reg, pos_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] check_reg;
    logic [7:0] payload_reg [8];

    logic [3:0] pos_off;
    logic [2:0] store_idx;
    logic       store_en;
    logic       check_en;
    logic       frame_ok;

    assign pos_off   = pos_reg - FIRST_DATA_POS;
    assign store_idx = pos_off[2:0];
    assign frame_ok  = (data_byte == match.tail_byte) && (xor_reg == check_reg);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        xor_next   = xor_reg;
        store_en   = 1'b0;
        check_en   = 1'b0;
        command.valid = 1'b0;
        unique case (phase_reg)
            PH_HEAD0:
            begin
                if (data_byte == match.first_header)
                begin
                    xor_next   = data_byte;
                    pos_next   = 4'd1;
                    phase_next = PH_HEAD1;
                end
            end
            PH_HEAD1:
            begin
                if (data_byte == match.second_header)
                begin
                    xor_next   = xor_reg ^ data_byte;
                    pos_next   = 4'd2;
                    phase_next = PH_TYPE;
                end
                else
                begin
                    phase_next = PH_HEAD0;
                end
            end
            PH_TYPE:
            begin
                if (data_byte == match.velocity_type)
                begin
                    xor_next   = xor_reg ^ data_byte;
                    pos_next   = FIRST_DATA_POS;
                    phase_next = PH_DATA;
                end
                else
                begin
                    phase_next = PH_HEAD0;
                end
            end
            PH_DATA:
            begin
                if (pos_reg < CHECK_POS)
                begin
                    store_en = 1'b1;
                    xor_next = xor_reg ^ data_byte;
                end
                else
                begin
                    check_en = 1'b1;
                end
                pos_next = pos_reg + 4'd1;
                if (pos_next >= TAIL_POS)
                begin
                    phase_next = PH_TAIL;
                end
            end
            PH_TAIL:
            begin
                command.valid = frame_ok;
                phase_next    = PH_HEAD0;
                pos_next      = 4'd0;
            end
            default:
            begin
                phase_next = PH_HEAD0;
                pos_next   = 4'd0;
            end
        endcase
        command.valid = command.valid & byte_en;

        // payload bytes are little endian: bytes 0..3 linear speed, 4..7 turn rate
        command.linear_speed_bits = {payload_reg[3], payload_reg[2],
                                     payload_reg[1], payload_reg[0]};
        command.turn_rate_bits    = {payload_reg[7], payload_reg[6],
                                     payload_reg[5], payload_reg[4]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD0;
            pos_reg   <= 4'd0;
            xor_reg   <= 8'd0;
        end
        else if (byte_en)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_en && store_en)
        begin
            payload_reg[store_idx] <= data_byte;
        end
        if (byte_en && check_en)
        begin
            check_reg <= data_byte;
        end
    end

endmodule

// ===== design/vcfr_watchdog.sv =====
// ----------------------------------------------------------------------------
// vcfr_watchdog
// Saturating millisecond counter; one stop event per timeout until re-armed.
// ----------------------------------------------------------------------------
module vcfr_watchdog
    import vcfr_pkg::*;
#(
    parameter int unsigned TICK_COUNTER_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_en,
    input  logic        rearm,
    input  logic [15:0] timeout_ms,
    output logic        stop
);

    localparam int unsigned CMP_WIDTH =
        (TICK_COUNTER_WIDTH > 16) ? TICK_COUNTER_WIDTH : 16;
    localparam logic [TICK_COUNTER_WIDTH-1:0] COUNT_MAX = '1;

    logic [TICK_COUNTER_WIDTH-1:0] count_reg, count_next;
    logic [TICK_COUNTER_WIDTH-1:0] count_inc;
    logic                          fired_reg, fired_next;
    logic [CMP_WIDTH-1:0]          count_ext;
    logic [CMP_WIDTH-1:0]          timeout_ext;

    // count after this tick, held at the top of the range
    assign count_inc   = (count_reg != COUNT_MAX) ? count_reg + 1'b1 : count_reg;
    assign count_ext   = CMP_WIDTH'(count_inc);
    assign timeout_ext = CMP_WIDTH'(timeout_ms);

    always_comb
    begin
        count_next = count_reg;
        fired_next = fired_reg;
        stop       = 1'b0;
        if (rearm)
        begin
            count_next = '0;
            fired_next = 1'b0;
        end
        else if (tick_en)
        begin
            count_next = count_inc;
            if ((count_ext > timeout_ext) && !fired_reg)
            begin
                fired_next = 1'b1;
                stop       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            fired_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            fired_reg <= fired_next;
        end
    end

endmodule

// ===== design/velocity_command_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// velocity_command_frame_receiver
// Serial velocity command frame parser with xor check and command watchdog.
// ----------------------------------------------------------------------------
// Takes one item per clock: a received byte or a millisecond tick. Each item
// is captured in an input register, handled by the frame parser or the
// watchdog, and its result (if any) is registered in the output register.
// Throughput is one item per cycle; the only thing that holds the input side
// is a result sitting unread in the output register while another item is
// already waiting in the input register. Configuration writes are always
// ready and are meant to happen while the block is idle.
module velocity_command_frame_receiver
    import vcfr_pkg::*;
#(
    parameter int unsigned TICK_COUNTER_WIDTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    vcfr_item_if.sink     item,
    vcfr_result_if.source result,
    vcfr_cfg_if.sink      cfg
);

    frame_match_t match_reg;
    logic [15:0]  timeout_reg;

    logic         in_valid_reg;
    logic         in_func_reg;
    logic [7:0]   in_byte_reg;

    logic         out_valid_reg;
    logic         out_kind_reg;
    logic [31:0]  out_linear_reg;
    logic [31:0]  out_turn_reg;

    logic         advance;
    logic         byte_en;
    logic         tick_en;
    logic         stop;
    command_t     command;

    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign byte_en = advance && (in_func_reg == FUNC_BYTE);
    assign tick_en = advance && (in_func_reg == FUNC_TICK);

    assign item.ready = !in_valid_reg || advance;
    assign cfg.ready  = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg.first_header  <= 8'd170;
            match_reg.second_header <= 8'd85;
            match_reg.velocity_type <= 8'd1;
            match_reg.tail_byte     <= 8'd13;
            timeout_reg             <= 16'd500;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FIRST_HEADER:  match_reg.first_header  <= cfg.data[7:0];
                CFG_SECOND_HEADER: match_reg.second_header <= cfg.data[7:0];
                CFG_VELOCITY_TYPE: match_reg.velocity_type <= cfg.data[7:0];
                CFG_TAIL_BYTE:     match_reg.tail_byte     <= cfg.data[7:0];
                CFG_TIMEOUT_MS:    timeout_reg             <= cfg.data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            in_func_reg <= item.func;
            in_byte_reg <= item.data_byte;
        end
    end

    vcfr_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (byte_en),
        .data_byte (in_byte_reg),
        .match     (match_reg),
        .command   (command)
    );

    vcfr_watchdog #(
        .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
    ) u_watchdog
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_en    (tick_en),
        .rearm      (command.valid),
        .timeout_ms (timeout_reg),
        .stop       (stop)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= command.valid || stop;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_kind_reg   <= stop ? EVENT_STOP : EVENT_COMMAND;
            out_linear_reg <= stop ? 32'd0 : command.linear_speed_bits;
            out_turn_reg   <= stop ? 32'd0 : command.turn_rate_bits;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.event_kind        = out_kind_reg;
    assign result.linear_speed_bits = out_linear_reg;
    assign result.turn_rate_bits    = out_turn_reg;

endmodule

// ===== design/vcfr_checker.sv =====
// ----------------------------------------------------------------------------
// vcfr_checker
// Port-level checks of the receiver, bound to the top level.
// ----------------------------------------------------------------------------
module vcfr_checker
    import vcfr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        item_valid,
    input logic        item_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic        event_kind,
    input logic [31:0] linear_speed_bits,
    input logic [31:0] turn_rate_bits
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(event_kind)
            && $stable(linear_speed_bits) && $stable(turn_rate_bits))
        else $error("stalled result changed");

    // stop events carry zero speeds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (event_kind == EVENT_STOP) |->
            (linear_speed_bits == 32'd0) && (turn_rate_bits == 32'd0))
        else $error("stop event with nonzero speed");

    // input backpressure only while a result waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> result_valid)
        else $error("input stalled with empty output");

    // a fresh result follows an earlier input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !$past(result_valid) |-> $past(item_valid && item_ready, 2))
        else $error("result without input transaction");

endmodule

bind velocity_command_frame_receiver vcfr_checker u_vcfr_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .event_kind        (result.event_kind),
    .linear_speed_bits (result.linear_speed_bits),
    .turn_rate_bits    (result.turn_rate_bits)
);
